FILE: design/led_pwm_pkg.sv
// Shared types, constants and the tangent table for the LED pixel PWM encoder.
// No dependencies.

package led_pwm_pkg;

    localparam int BitsPerPixel      = 24;
    localparam int ScaleFracBitsDef  = 16;
    localparam int TableFrac         = 16;
    localparam int MaxAngle          = 45;
    localparam int MaxSlots          = 64;
    localparam int QueueDepth        = 4;
    localparam int CntW              = $clog2(MaxSlots);
    localparam int CfgIdxW           = 3;
    localparam int CfgDataW          = 8;

    localparam logic [5:0] BrightnessRst = 6'd45;
    localparam logic [7:0] OneCodeRst    = 8'd60;
    localparam logic [7:0] ZeroCodeRst   = 8'd30;
    localparam logic [6:0] ResetSlotsRst = 7'd50;

    localparam logic OpPixel = 1'b0;
    localparam logic OpLatch = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CfgBrightness = 3'd0,
        CfgOneCode    = 3'd1,
        CfgZeroCode   = 3'd2,
        CfgResetSlots = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [5:0] brightness;
        logic [7:0] one_code;
        logic [7:0] zero_code;
        logic [6:0] reset_slots;
    } t_cfg;

    typedef struct packed {
        logic                    is_latch;
        logic [BitsPerPixel-1:0] word;
    } t_item;

    // round(tan(d) * 2^16), angles above the top entry saturate
    function automatic logic [16:0] tan_q16(input logic [5:0] angle);
        logic [16:0] t;
        case (angle)
            6'd0:  t = 17'd0;
            6'd1:  t = 17'd1144;
            6'd2:  t = 17'd2289;
            6'd3:  t = 17'd3435;
            6'd4:  t = 17'd4583;
            6'd5:  t = 17'd5734;
            6'd6:  t = 17'd6888;
            6'd7:  t = 17'd8047;
            6'd8:  t = 17'd9210;
            6'd9:  t = 17'd10380;
            6'd10: t = 17'd11556;
            6'd11: t = 17'd12739;
            6'd12: t = 17'd13930;
            6'd13: t = 17'd15130;
            6'd14: t = 17'd16340;
            6'd15: t = 17'd17560;
            6'd16: t = 17'd18792;
            6'd17: t = 17'd20036;
            6'd18: t = 17'd21294;
            6'd19: t = 17'd22566;
            6'd20: t = 17'd23853;
            6'd21: t = 17'd25157;
            6'd22: t = 17'd26478;
            6'd23: t = 17'd27818;
            6'd24: t = 17'd29179;
            6'd25: t = 17'd30560;
            6'd26: t = 17'd31964;
            6'd27: t = 17'd33392;
            6'd28: t = 17'd34846;
            6'd29: t = 17'd36327;
            6'd30: t = 17'd37837;
            6'd31: t = 17'd39378;
            6'd32: t = 17'd40951;
            6'd33: t = 17'd42560;
            6'd34: t = 17'd44205;
            6'd35: t = 17'd45889;
            6'd36: t = 17'd47615;
            6'd37: t = 17'd49385;
            6'd38: t = 17'd51202;
            6'd39: t = 17'd53070;
            6'd40: t = 17'd54991;
            6'd41: t = 17'd56970;
            6'd42: t = 17'd59009;
            6'd43: t = 17'd61113;
            6'd44: t = 17'd63287;
            default: t = 17'd65536;
        endcase
        return t;
    endfunction

endpackage

FILE: design/led_pwm_front.sv
// Front end: input stage, brightness scaling and GRB packing into queue items.
// Depends on led_pwm_pkg.

module led_pwm_front #(
    parameter int SCALE_FRACTION_BITS = led_pwm_pkg::ScaleFracBitsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic [5:0]          i_brightness,
    input  logic                i_full,
    output logic                o_push,
    output led_pwm_pkg::t_item  o_item
);

    localparam int F    = SCALE_FRACTION_BITS;
    localparam int EW   = F + 1;
    localparam int PW   = 8 + EW;
    localparam int Up   = (F >= led_pwm_pkg::TableFrac) ? (F - led_pwm_pkg::TableFrac) : 0;
    localparam int Dn   = (F < led_pwm_pkg::TableFrac) ? (led_pwm_pkg::TableFrac - F) : 0;
    localparam int WW   = 17 + Up + 1;
    localparam logic [WW-1:0] Half = (Dn > 0) ? (WW'(1) << (Dn - 1)) : '0;

    logic          r_a_valid;
    logic          r_a_op;
    logic [7:0]    r_a_red;
    logic [7:0]    r_a_green;
    logic [7:0]    r_a_blue;
    logic [EW-1:0] r_entry;
    logic [WW-1:0] n_entry_wide;
    logic [7:0]    w_r, w_g, w_b;

    function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [EW-1:0] e);
        logic [PW-1:0] p;
        logic [8:0]    q;
        p = PW'(ch) * PW'(e);
        q = 9'(p >> F);
        return q[8] ? 8'hFF : q[7:0];
    endfunction

    assign n_entry_wide = ((WW'(led_pwm_pkg::tan_q16(i_brightness)) << Up) + Half) >> Dn;

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry_wide[EW-1:0];
    end

    assign o_push     = r_a_valid && !i_full;
    assign o_in_ready = !r_a_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_op    <= i_op;
            r_a_red   <= i_red;
            r_a_green <= i_green;
            r_a_blue  <= i_blue;
        end
    end

    always_comb begin
        w_r = scale_ch(r_a_red, r_entry);
        w_g = scale_ch(r_a_green, r_entry);
        w_b = scale_ch(r_a_blue, r_entry);
        o_item.is_latch = (r_a_op == led_pwm_pkg::OpLatch);
        o_item.word     = o_item.is_latch ? '0 : {w_g, w_r, w_b};
    end

endmodule

FILE: design/led_pwm_fifo.sv
// Short item queue between front and back ends.
// Depends on led_pwm_pkg.

module led_pwm_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  led_pwm_pkg::t_item  i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output led_pwm_pkg::t_item  o_item
);

    localparam int Depth = led_pwm_pkg::QueueDepth;
    localparam int AW    = $clog2(Depth);

    led_pwm_pkg::t_item r_mem [Depth];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW:0]        r_count;

    assign o_full  = (r_count == (AW+1)'(Depth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

endmodule

FILE: design/led_pwm_back.sv
// Back end: serialises queued items into duty slots with an output register.
// Depends on led_pwm_pkg.

module led_pwm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  led_pwm_pkg::t_cfg   i_cfg,
    input  logic                i_q_valid,
    input  led_pwm_pkg::t_item  i_q_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_duty,
    output logic                o_last
);

    localparam int BPP  = led_pwm_pkg::BitsPerPixel;
    localparam int CntW = led_pwm_pkg::CntW;

    logic                r_busy, n_busy;
    logic                r_latch, n_latch;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic [BPP-1:0]      r_word, n_word;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_duty, n_duty;
    logic                r_last, n_last;
    logic                w_adv;
    logic [6:0]          w_slots;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_duty      = r_duty;
    assign o_last      = r_last;

    always_comb begin
        if (i_cfg.reset_slots == 7'd0) begin
            w_slots = 7'd1;
        end else if (i_cfg.reset_slots > 7'(led_pwm_pkg::MaxSlots)) begin
            w_slots = 7'(led_pwm_pkg::MaxSlots);
        end else begin
            w_slots = i_cfg.reset_slots;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_latch     = r_latch;
        n_cnt       = r_cnt;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_duty      = r_duty;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (w_adv) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_duty      = r_latch ? 8'd0 :
                              (r_word[BPP-1] ? i_cfg.one_code : i_cfg.zero_code);
                n_last      = (r_cnt == CntW'(1));
                n_word      = {r_word[BPP-2:0], 1'b0};
                n_cnt       = r_cnt - 1'b1;
                n_busy      = (r_cnt != CntW'(1));
            end else if (i_q_valid) begin
                o_pop       = 1'b1;
                n_out_valid = 1'b1;
                n_latch     = i_q_item.is_latch;
                n_word      = {i_q_item.word[BPP-2:0], 1'b0};
                if (i_q_item.is_latch) begin
                    n_duty = 8'd0;
                    n_cnt  = CntW'(w_slots - 7'd1);
                end else begin
                    n_duty = i_q_item.word[BPP-1] ? i_cfg.one_code : i_cfg.zero_code;
                    n_cnt  = CntW'(BPP - 1);
                end
                n_last = (n_cnt == '0);
                n_busy = (n_cnt != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_latch <= n_latch;
        r_cnt   <= n_cnt;
        r_word  <= n_word;
        r_duty  <= n_duty;
        r_last  <= n_last;
    end

    a_busy_has_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("busy with no slots remaining");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy && w_adv))
        else $error("pop while a run is in progress");

endmodule

FILE: design/led_pixel_pwm_encoder.sv
// Top level of the LED pixel PWM encoder: configuration registers and wiring.
// Depends on led_pwm_pkg, led_pwm_front, led_pwm_fifo, led_pwm_back.

// A pixel item yields 24 duty slots (green, red, blue, MSB first) and a latch
// item yields reset_slots slots (1 to 64) of zero duty; the final slot of each
// run has o_last set. The output serialiser emits one slot per cycle unless
// i_out_ready stalls it; the input side takes one item per cycle until the
// input stage and four-entry queue are full, and an item reaching an idle
// block passes the input stage, the queue and the output register before its
// first slot is presented. Configuration writes are always ready
// and also reach items still held inside, so write only while the block is idle.

module led_pixel_pwm_encoder #(
    parameter int SCALE_FRACTION_BITS = led_pwm_pkg::ScaleFracBitsDef
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [7:0]                         i_red,
    input  logic [7:0]                         i_green,
    input  logic [7:0]                         i_blue,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_duty,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [led_pwm_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [led_pwm_pkg::CfgDataW-1:0]   i_cfg_data
);

    led_pwm_pkg::t_cfg  r_cfg;
    led_pwm_pkg::t_item w_push_item;
    led_pwm_pkg::t_item w_q_item;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_q_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness  <= led_pwm_pkg::BrightnessRst;
            r_cfg.one_code    <= led_pwm_pkg::OneCodeRst;
            r_cfg.zero_code   <= led_pwm_pkg::ZeroCodeRst;
            r_cfg.reset_slots <= led_pwm_pkg::ResetSlotsRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                led_pwm_pkg::CfgBrightness: r_cfg.brightness  <= i_cfg_data[5:0];
                led_pwm_pkg::CfgOneCode:    r_cfg.one_code    <= i_cfg_data;
                led_pwm_pkg::CfgZeroCode:   r_cfg.zero_code   <= i_cfg_data;
                led_pwm_pkg::CfgResetSlots: r_cfg.reset_slots <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    led_pwm_front #(
        .SCALE_FRACTION_BITS(SCALE_FRACTION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_brightness (r_cfg.brightness),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    led_pwm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    led_pwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_duty      (o_duty),
        .o_last      (o_last)
    );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for led_pixel_pwm_encoder: pixels and latch gaps are
// sent under random idling; every duty slot is checked against a local predictor.
// Depends on led_pwm_pkg and the encoder RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int ScaleFrac = 16;
    localparam logic [2:0] CfgSpareLo = 3'd4;
    localparam logic [2:0] CfgSpareHi = 3'd7;

    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } t_slot;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_op = led_pwm_pkg::OpPixel;
    logic [7:0] i_red = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_blue = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_duty;
    logic       o_last;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [led_pwm_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [led_pwm_pkg::CfgDataW-1:0] i_cfg_data = '0;

    // round(tan(d) * 2^16), d = 0..45
    logic [16:0] angle_tan [46] = '{
            17'd0,  17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
         17'd6888,  17'd8047,  17'd9210, 17'd10380, 17'd11556, 17'd12739,
        17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
        17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
        17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
        17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
        17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
        17'd59009, 17'd61113, 17'd63287, 17'd65536
    };

    logic [5:0] cur_brightness  = led_pwm_pkg::BrightnessRst;
    logic [7:0] cur_one_code    = led_pwm_pkg::OneCodeRst;
    logic [7:0] cur_zero_code   = led_pwm_pkg::ZeroCodeRst;
    logic [6:0] cur_reset_slots = led_pwm_pkg::ResetSlotsRst;

    t_slot expected_slots [$];
    int    error_count = 0;
    int    send_idle_pct = 16;
    int    recv_stall_pct = 73;

    led_pixel_pwm_encoder #(
        .SCALE_FRACTION_BITS(ScaleFrac)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_duty      (o_duty),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_slot exp_slot;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_slots.size() == 0) begin
                $error("unexpected slot: duty %0d last %0d", o_duty, o_last);
                error_count++;
            end else begin
                exp_slot = expected_slots.pop_front();
                if (o_duty !== exp_slot.duty) begin
                    $error("duty: expected %0d, got %0d", exp_slot.duty, o_duty);
                    error_count++;
                end
                if (o_last !== exp_slot.last) begin
                    $error("last: expected %0d, got %0d", exp_slot.last, o_last);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [7:0] scale_colour(input logic [7:0] ch);
        logic [5:0]  angle;
        logic [40:0] factor;
        logic [63:0] prod;
        int          dn;
        angle = (cur_brightness > led_pwm_pkg::MaxAngle) ?
                6'(led_pwm_pkg::MaxAngle) : cur_brightness;
        factor = 41'(angle_tan[angle]);
        if (ScaleFrac >= 16) begin
            factor = factor << (ScaleFrac - 16);
        end else begin
            dn = 16 - ScaleFrac;
            factor = (factor + (41'd1 << (dn - 1))) >> dn;
        end
        prod = (64'(ch) * 64'(factor)) >> ScaleFrac;
        return (prod > 64'd255) ? 8'hFF : prod[7:0];
    endfunction

    task automatic predict_slots(input logic op, input logic [7:0] r, g, b);
        logic [23:0] grb;
        int          n;
        if (op == led_pwm_pkg::OpLatch) begin
            n = int'(cur_reset_slots);
            if (n < 1) n = 1;
            if (n > led_pwm_pkg::MaxSlots) n = led_pwm_pkg::MaxSlots;
            for (int k = 0; k < n; k++) begin
                expected_slots.push_back('{duty: 8'd0, last: (k == n - 1)});
            end
        end else begin
            grb = {scale_colour(g), scale_colour(r), scale_colour(b)};
            for (int k = 0; k < led_pwm_pkg::BitsPerPixel; k++) begin
                expected_slots.push_back('{
                    duty: grb[led_pwm_pkg::BitsPerPixel - 1 - k] ?
                          cur_one_code : cur_zero_code,
                    last: (k == led_pwm_pkg::BitsPerPixel - 1)});
            end
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] r, g, b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_slots(op, r, g, b);
    endtask

    // leaves the input channel low and waits for every pending slot
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_slots.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        unique case (idx)
            led_pwm_pkg::CfgBrightness: cur_brightness = data[5:0];
            led_pwm_pkg::CfgOneCode:    cur_one_code = data;
            led_pwm_pkg::CfgZeroCode:   cur_zero_code = data;
            led_pwm_pkg::CfgResetSlots: cur_reset_slots = data[6:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] bright, one, zero, slots);
        drain_pipeline();
        write_reg(led_pwm_pkg::CfgBrightness, bright);
        write_reg(led_pwm_pkg::CfgOneCode, one);
        write_reg(led_pwm_pkg::CfgZeroCode, zero);
        write_reg(led_pwm_pkg::CfgResetSlots, slots);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_item(led_pwm_pkg::OpPixel, 8'h81, 8'h7E, 8'h00);
        send_item(led_pwm_pkg::OpLatch, 8'h00, 8'h00, 8'h00);
        send_item(led_pwm_pkg::OpPixel, 8'hFF, 8'h01, 8'h80);
    endtask

    task automatic test_field_extremes();
        configure(8'd45, 8'hFF, 8'h00, 8'd1);
        send_item(led_pwm_pkg::OpPixel, 8'h00, 8'h00, 8'h00);
        send_item(led_pwm_pkg::OpPixel, 8'hFF, 8'hFF, 8'hFF);
        send_item(led_pwm_pkg::OpPixel, 8'hA5, 8'h5A, 8'h3C);
        send_item(led_pwm_pkg::OpLatch, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_brightness_range();
        configure(8'd0, 8'h00, 8'hFF, 8'd50);
        send_item(led_pwm_pkg::OpPixel, 8'hFF, 8'hFF, 8'hFF);
        configure(8'd1, 8'h55, 8'hAA, 8'd50);
        send_item(led_pwm_pkg::OpPixel, 8'hFF, 8'h80, 8'h7F);
        configure(8'd44, 8'hAA, 8'h55, 8'd50);
        send_item(led_pwm_pkg::OpPixel, 8'hFF, 8'hC3, 8'h01);
        // above the top angle: treated as unity
        configure(8'hFF, 8'h3C, 8'h1E, 8'd50);
        send_item(led_pwm_pkg::OpPixel, 8'hFE, 8'h7F, 8'h80);
        configure(8'd46, 8'h3C, 8'h1E, 8'd50);
        send_item(led_pwm_pkg::OpPixel, 8'h12, 8'h34, 8'h56);
    endtask

    task automatic test_latch_lengths();
        // zero slots behaves as one; above 64 saturates
        configure(8'd45, 8'd60, 8'd30, 8'd0);
        send_item(led_pwm_pkg::OpLatch, 8'hAA, 8'h55, 8'hFF);
        configure(8'd45, 8'd60, 8'd30, 8'd64);
        send_item(led_pwm_pkg::OpLatch, 8'h00, 8'hFF, 8'h00);
        configure(8'd45, 8'd60, 8'd30, 8'd65);
        send_item(led_pwm_pkg::OpLatch, 8'h00, 8'h00, 8'h00);
        configure(8'd45, 8'd60, 8'd30, 8'hFF);
        send_item(led_pwm_pkg::OpLatch, 8'h00, 8'h00, 8'h00);
        send_item(led_pwm_pkg::OpPixel, 8'h0F, 8'hF0, 8'h99);
    endtask

    task automatic test_unknown_index();
        drain_pipeline();
        for (int i = int'(CfgSpareLo); i <= int'(CfgSpareHi); i++) begin
            write_reg(3'(i), 8'hFF);
        end
        i_cfg_valid <= 1'b0;
        send_item(led_pwm_pkg::OpPixel, 8'h5A, 8'hA5, 8'hC3);
        send_item(led_pwm_pkg::OpLatch, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_random_traffic(input int idle_pct, stall_pct, count);
        logic op;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            op = ($urandom_range(9) < 2) ? led_pwm_pkg::OpLatch : led_pwm_pkg::OpPixel;
            send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_brightness_range();
        test_latch_lengths();
        test_unknown_index();
        test_random_traffic(16, 73, 34);
        test_random_traffic(73, 16, 34);
        test_random_traffic(0, 0, 34);
        drain_pipeline();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/led_pwm_pkg.sv
design/led_pwm_front.sv
design/led_pwm_fifo.sv
design/led_pwm_back.sv
design/led_pixel_pwm_encoder.sv
dv/testbench.sv
